// File: src/bfbp_pkg.sv
package bfbp_pkg;

  // Fixed field widths on the stream ports
  localparam int unsigned IN_ADDR_W  = 32;
  localparam int unsigned IN_SIZE_W  = 16;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_ADDR_W = 32;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic {
    KIND_FREE  = 1'b0,
    KIND_ALLOC = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_TAIL
  } state_e;

  typedef struct packed {
    logic  valid;
    kind_e kind;
  } req_ctrl_t;

endpackage

// File: src/bfbp_front.sv
module bfbp_front #(
  parameter int unsigned ADDR_BITS = 32,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bfbp_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tuser,
  output bfbp_pkg::req_ctrl_t            req_ctrl_o,
  output logic [ADDR_BITS-1:0]           req_addr_o,
  output logic [SIZE_BITS-1:0]           req_size_o,
  input  logic                           req_pop_i
);
  import bfbp_pkg::*;

  localparam int unsigned DEPTH = 2;

  kind_e                kind_q [DEPTH];
  logic [ADDR_BITS-1:0] addr_q [DEPTH];
  logic [SIZE_BITS-1:0] size_q [DEPTH];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           fill_q, fill_d;

  logic [ADDR_BITS+IN_ADDR_W-1:0] addr_ext;
  logic [SIZE_BITS+IN_SIZE_W-1:0] size_ext;
  kind_e                          kind_in;
  logic                           push;
  logic                           pop;

  // Fit the port fields to the table widths
  assign addr_ext = {{ADDR_BITS{1'b0}}, s_axis_tdata[IN_ADDR_W-1:0]};
  assign size_ext = {{SIZE_BITS{1'b0}}, s_axis_tdata[IN_DATA_W-1:IN_ADDR_W]};
  assign kind_in  = s_axis_tuser ? KIND_ALLOC : KIND_FREE;

  assign s_axis_tready = (fill_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = req_pop_i && (fill_q != 2'd0);

  assign req_ctrl_o.valid = (fill_q != 2'd0);
  assign req_ctrl_o.kind  = kind_q[rd_ptr_q];
  assign req_addr_o       = addr_q[rd_ptr_q];
  assign req_size_o       = size_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wr_ptr_q] <= kind_in;
      addr_q[wr_ptr_q] <= addr_ext[ADDR_BITS-1:0];
      size_q[wr_ptr_q] <= size_ext[SIZE_BITS-1:0];
    end
  end

endmodule

// File: src/bfbp_back.sv
module bfbp_back #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned ADDR_BITS     = 32,
  parameter int unsigned SIZE_BITS     = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bfbp_pkg::req_ctrl_t              req_ctrl_i,
  input  logic [ADDR_BITS-1:0]             req_addr_i,
  input  logic [SIZE_BITS-1:0]             req_size_i,
  output logic                             req_pop_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bfbp_pkg::OUT_ADDR_W-1:0]  m_axis_tdata,
  output logic [bfbp_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
  import bfbp_pkg::*;

  localparam int unsigned IDXW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNTW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ENTW  = ADDR_BITS + SIZE_BITS;
  localparam logic [CNTW-1:0] FULL = CNTW'(TABLE_ENTRIES);

  logic [ENTW-1:0] mem_q [TABLE_ENTRIES];
  logic [ENTW-1:0] rd_data_q;
  logic [IDXW-1:0] rd_idx;
  logic            wr_en;
  logic [IDXW-1:0] wr_idx;
  logic [ENTW-1:0] wr_data;

  state_e               state_q, state_d;
  logic [CNTW-1:0]      count_q, count_d;
  logic [CNTW-1:0]      ptr_q, ptr_d;
  logic                 have_q, have_d;
  logic [CNTW-1:0]      best_idx_q, best_idx_d;
  logic [SIZE_BITS-1:0] best_size_q, best_size_d;
  logic [ADDR_BITS-1:0] best_addr_q, best_addr_d;
  logic [SIZE_BITS-1:0] req_size_q, req_size_d;

  logic                 res_valid_q, res_valid_d;
  logic [ADDR_BITS-1:0] res_addr_q, res_addr_d;
  logic                 res_found_q, res_found_d;
  logic                 res_dropped_q, res_dropped_d;
  logic                 out_free;

  logic [SIZE_BITS-1:0] rd_size;
  logic [ADDR_BITS-1:0] rd_addr;
  logic                 take;
  logic                 n_have;
  logic [CNTW-1:0]      n_idx;
  logic [SIZE_BITS-1:0] n_size;
  logic [ADDR_BITS-1:0] n_addr;
  logic [CNTW-1:0]      cnt_m1;
  logic [CNTW-1:0]      ptr_p1;
  logic [CNTW-1:0]      ptr_p2;
  logic [CNTW-1:0]      n_idx_p1;
  logic [ENTW-1:0]      sz_ext;
  logic [ADDR_BITS-1:0] tail_addr;
  logic [SIZE_BITS-1:0] tail_size;
  logic [ADDR_BITS+OUT_ADDR_W-1:0] out_ext;

  assign rd_size   = rd_data_q[SIZE_BITS-1:0];
  assign rd_addr   = rd_data_q[ENTW-1:SIZE_BITS];
  assign cnt_m1    = count_q - CNTW'(1);
  assign ptr_p1    = ptr_q + CNTW'(1);
  assign ptr_p2    = ptr_q + CNTW'(2);
  assign n_idx_p1  = n_idx + CNTW'(1);
  assign sz_ext    = {{ADDR_BITS{1'b0}}, req_size_q};
  assign tail_addr = best_addr_q + sz_ext[ADDR_BITS-1:0];
  assign tail_size = best_size_q - req_size_q;

  // Smallest fitting size wins; strict compare keeps the oldest on a tie
  assign take   = (rd_size >= req_size_q) && (!have_q || (rd_size < best_size_q));
  assign n_have = have_q || take;
  assign n_idx  = take ? ptr_q : best_idx_q;
  assign n_size = take ? rd_size : best_size_q;
  assign n_addr = take ? rd_addr : best_addr_q;

  assign out_free = !res_valid_q || m_axis_tready;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    ptr_d         = ptr_q;
    have_d        = have_q;
    best_idx_d    = best_idx_q;
    best_size_d   = best_size_q;
    best_addr_d   = best_addr_q;
    req_size_d    = req_size_q;
    req_pop_o     = 1'b0;
    rd_idx        = '0;
    wr_en         = 1'b0;
    wr_idx        = '0;
    wr_data       = rd_data_q;
    res_valid_d   = res_valid_q && !m_axis_tready;
    res_addr_d    = res_addr_q;
    res_found_d   = res_found_q;
    res_dropped_d = res_dropped_q;

    case (state_q)
      ST_IDLE: begin
        if (req_ctrl_i.valid && out_free) begin
          req_pop_o  = 1'b1;
          req_size_d = req_size_i;
          if (req_ctrl_i.kind == KIND_FREE) begin
            res_valid_d   = 1'b1;
            res_addr_d    = '0;
            res_found_d   = 1'b0;
            res_dropped_d = (count_q == FULL);
            if (count_q != FULL) begin
              wr_en   = 1'b1;
              wr_idx  = count_q[IDXW-1:0];
              wr_data = {req_addr_i, req_size_i};
              count_d = count_q + CNTW'(1);
            end
          end else if (count_q == '0) begin
            res_valid_d   = 1'b1;
            res_addr_d    = '0;
            res_found_d   = 1'b0;
            res_dropped_d = 1'b0;
          end else begin
            ptr_d   = '0;
            have_d  = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        have_d      = n_have;
        best_idx_d  = n_idx;
        best_size_d = n_size;
        best_addr_d = n_addr;
        if (ptr_q == cnt_m1) begin
          if (!n_have) begin
            res_valid_d   = 1'b1;
            res_addr_d    = '0;
            res_found_d   = 1'b0;
            res_dropped_d = 1'b0;
            state_d       = ST_IDLE;
          end else if (n_idx == cnt_m1) begin
            state_d = ST_TAIL;
          end else begin
            // Start closing the gap at the chosen entry
            rd_idx  = n_idx_p1[IDXW-1:0];
            ptr_d   = n_idx;
            state_d = ST_SHIFT;
          end
        end else begin
          rd_idx = ptr_p1[IDXW-1:0];
          ptr_d  = ptr_p1;
        end
      end
      ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_idx  = ptr_q[IDXW-1:0];
        wr_data = rd_data_q;
        if (ptr_p2 == count_q) begin
          state_d = ST_TAIL;
        end else begin
          rd_idx = ptr_p2[IDXW-1:0];
          ptr_d  = ptr_p1;
        end
      end
      ST_TAIL: begin
        res_valid_d   = 1'b1;
        res_addr_d    = best_addr_q;
        res_found_d   = 1'b1;
        res_dropped_d = 1'b0;
        if (best_size_q > req_size_q) begin
          wr_en   = 1'b1;
          wr_idx  = cnt_m1[IDXW-1:0];
          wr_data = {tail_addr, tail_size};
        end else begin
          count_d = cnt_m1;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q         <= ptr_d;
    have_q        <= have_d;
    best_idx_q    <= best_idx_d;
    best_size_q   <= best_size_d;
    best_addr_q   <= best_addr_d;
    req_size_q    <= req_size_d;
    res_addr_q    <= res_addr_d;
    res_found_q   <= res_found_d;
    res_dropped_q <= res_dropped_d;
  end

  // Block table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    rd_data_q <= mem_q[rd_idx];
  end

  assign out_ext       = {{OUT_ADDR_W{1'b0}}, res_addr_q};
  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = out_ext[OUT_ADDR_W-1:0];
  assign m_axis_tuser  = {res_dropped_q, res_found_q};

endmodule

// File: src/best_fit_block_pool.sv
// Best-fit free-block table with stream channels.
// Input beat (s_axis): tuser is the command (0 return a block, 1 allocate),
// tdata carries the block address and the block or request size. Every
// input beat yields exactly one output beat (m_axis): tdata is the granted
// address, tuser flags found and dropped.
// A two-entry request queue accepts beats while the table engine works.
// Return: answered from idle, one per cycle while m_axis_tready is high.
// Allocate: the engine reads the table one entry a cycle through its single
// read port; the output beat follows a full scan of the stored blocks, a
// shift that closes the gap behind the chosen entry unless it is the last,
// and the tail write-back. A miss answers after the scan, an empty table
// straight from idle.
// Reset empties the table and the queue at once; no clearing pass is needed.
// The output beat sits in a register until taken; while m_axis_tready is low
// the engine holds and the queue keeps accepting until it is full, after
// which s_axis_tready drops.
module best_fit_block_pool #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned ADDR_BITS     = 32,
  parameter int unsigned SIZE_BITS     = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] block_addr, [47:32] block_size
  input  logic [bfbp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] cmd
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] alloc_addr
  output logic [bfbp_pkg::OUT_ADDR_W-1:0] m_axis_tdata,
  // [0] found, [1] dropped
  output logic [bfbp_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import bfbp_pkg::*;

  req_ctrl_t            req_ctrl;
  logic [ADDR_BITS-1:0] req_addr;
  logic [SIZE_BITS-1:0] req_size;
  logic                 req_pop;

  bfbp_front #(
    .ADDR_BITS (ADDR_BITS),
    .SIZE_BITS (SIZE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .req_ctrl_o    (req_ctrl),
    .req_addr_o    (req_addr),
    .req_size_o    (req_size),
    .req_pop_i     (req_pop)
  );

  bfbp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDR_BITS     (ADDR_BITS),
    .SIZE_BITS     (SIZE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_ctrl_i    (req_ctrl),
    .req_addr_i    (req_addr),
    .req_size_i    (req_size),
    .req_pop_o     (req_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: tb/tb_best_fit_block_pool.sv
module tb_best_fit_block_pool;
  import bfbp_pkg::*;

  localparam int POOL_DEPTH    = 64;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    logic [OUT_ADDR_W-1:0] addr;
    logic                  found;
    logic                  dropped;
  } pool_reply_t;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_ADDR_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  always #5 clk_i = ~clk_i;

  best_fit_block_pool u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  // Shadow of the free-block table, oldest entry first
  logic [IN_ADDR_W-1:0] free_addr [POOL_DEPTH];
  logic [IN_SIZE_W-1:0] free_size [POOL_DEPTH];
  int                   free_count = 0;

  pool_reply_t reply_q[$];

  int errors    = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_granted = 0;
  int n_missed  = 0;
  int n_dropped = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  function automatic pool_reply_t predict_pool_reply(kind_e kind, logic [IN_ADDR_W-1:0] a,
                                                     logic [IN_SIZE_W-1:0] sz);
    pool_reply_t          r;
    int                   best;
    logic [IN_ADDR_W-1:0] baddr;
    logic [IN_SIZE_W-1:0] bsize;
    r.addr    = '0;
    r.found   = 1'b0;
    r.dropped = 1'b0;
    best      = -1;
    if (kind == KIND_FREE) begin
      if (free_count >= POOL_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        free_addr[free_count] = a;
        free_size[free_count] = sz;
        free_count++;
      end
    end else begin
      // strict less-than keeps the oldest among equal sizes
      for (int i = 0; i < free_count; i++)
        if (free_size[i] >= sz && (best < 0 || free_size[i] < free_size[best])) best = i;
      if (best >= 0) begin
        baddr = free_addr[best];
        bsize = free_size[best];
        for (int i = best; i + 1 < free_count; i++) begin
          free_addr[i] = free_addr[i + 1];
          free_size[i] = free_size[i + 1];
        end
        free_count--;
        if (bsize > sz) begin
          free_addr[free_count] = baddr + IN_ADDR_W'(sz);
          free_size[free_count] = bsize - sz;
          free_count++;
        end
        r.addr  = baddr;
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  // Mostly zero or short, now and then long
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [IN_ADDR_W-1:0] rand_addr();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return {16'hFFFF, 16'($urandom)};
    if (roll < 14) return '0;
    if (roll < 18) return '1;
    return $urandom;
  endfunction

  task automatic send_req(kind_e kind, logic [IN_ADDR_W-1:0] a, logic [IN_SIZE_W-1:0] sz);
    int          gap;
    pool_reply_t r;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {sz, a};
    s_tuser  <= kind;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    r = predict_pool_reply(kind, a, sz);
    reply_q.insert(reply_q.size(), r);
    n_sent++;
    if (r.dropped) n_dropped++;
    if (kind == KIND_ALLOC) begin
      if (r.found) n_granted++;
      else n_missed++;
    end
  endtask

  task automatic send_random_req();
    int                   roll;
    int                   free_pct;
    int                   idx;
    logic [IN_SIZE_W-1:0] sz;
    free_pct = (free_count < 8) ? 80 : (free_count > 48) ? 30 : 50;
    roll     = $urandom_range(0, 99);
    idx      = (free_count > 0) ? $urandom_range(0, free_count - 1) : 0;
    if ($urandom_range(0, 99) < free_pct) begin
      if (roll < 65) sz = IN_SIZE_W'($urandom_range(1, 256));
      else if (roll < 80) sz = IN_SIZE_W'($urandom_range(0, 8));
      else if (roll < 90 && free_count > 0) sz = free_size[idx];
      else sz = IN_SIZE_W'($urandom_range(0, 65535));
      send_req(KIND_FREE, rand_addr(), sz);
    end else begin
      if (roll < 60 && free_count > 0) sz = IN_SIZE_W'($urandom_range(0, free_size[idx]));
      else if (roll < 80) sz = IN_SIZE_W'($urandom_range(0, 300));
      else sz = IN_SIZE_W'($urandom_range(0, 65535));
      send_req(KIND_ALLOC, $urandom, sz);
    end
  endtask

  task automatic test_directed();
    send_req(KIND_ALLOC, 32'h0000_0000, 16'd1);
    send_req(KIND_ALLOC, 32'hFFFF_FFFF, 16'd0);
    send_req(KIND_FREE,  32'h0000_1000, 16'd0);
    send_req(KIND_ALLOC, 32'h0000_0000, 16'd0);
    send_req(KIND_FREE,  32'h0000_0000, 16'd100);
    // granted address zero, exact fit, address field ignored
    send_req(KIND_ALLOC, 32'hFFFF_FFFF, 16'd100);
    send_req(KIND_FREE,  32'hFFFF_FFF0, 16'hFFFF);
    // tail address wraps past the top
    send_req(KIND_ALLOC, 32'h0000_0000, 16'h0020);
    send_req(KIND_FREE,  32'hA000_0000, 16'd50);
    send_req(KIND_FREE,  32'hB000_0000, 16'd50);
    send_req(KIND_FREE,  32'hC000_0000, 16'd30);
    send_req(KIND_ALLOC, 32'h0000_0000, 16'd40);
    // zero-size request takes the smallest entry and re-appends it
    send_req(KIND_ALLOC, 32'h0000_0000, 16'd0);
    send_req(KIND_ALLOC, 32'h0000_0000, 16'd50);
    send_req(KIND_ALLOC, 32'h0000_0000, 16'hFFFF);
    send_req(KIND_FREE,  32'hFFFF_FFFF, 16'hFFFF);
    send_req(KIND_ALLOC, 32'h5555_5555, 16'hFFFF);
    send_req(KIND_FREE,  32'h5555_5555, 16'hAAAA);
    send_req(KIND_FREE,  32'hAAAA_AAAA, 16'h5555);
    send_req(KIND_ALLOC, 32'h0000_0000, 16'h5556);
    send_req(KIND_ALLOC, 32'h0000_0000, 16'd31);
  endtask

  task automatic test_table_full();
    while (free_count < POOL_DEPTH)
      send_req(KIND_FREE, $urandom, IN_SIZE_W'($urandom_range(1, 512)));
    repeat (4) send_req(KIND_FREE, $urandom, IN_SIZE_W'($urandom_range(0, 65535)));
    // a tail lands in the slot just freed, so the table stays full
    send_req(KIND_ALLOC, $urandom, free_size[$urandom_range(0, POOL_DEPTH - 1)] - 16'd1);
    send_req(KIND_FREE, $urandom, IN_SIZE_W'($urandom_range(0, 65535)));
    send_req(KIND_ALLOC, $urandom, 16'hFFFF);
    send_req(KIND_ALLOC, $urandom, free_size[$urandom_range(0, POOL_DEPTH - 1)]);
    send_req(KIND_FREE, $urandom, IN_SIZE_W'($urandom_range(0, 65535)));
    repeat (6) send_req(KIND_ALLOC, $urandom, IN_SIZE_W'($urandom_range(0, 400)));
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_random_req();
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat (20) send_random_req();
      // hold the input until every pending result is out
      s_tvalid <= 1'b0;
      while (reply_q.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    repeat (150) send_random_req();
    calm = 1'b0;
  endtask

  // Check each result beat and drive the ready side
  always @(posedge clk_i) begin
    pool_reply_t e;
    int          idle;
    if (rst_ni && m_tvalid && m_tready) begin
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, actual addr %h user %b", $time, m_tdata, m_tuser);
      end else begin
        e = reply_q.pop_front();
        n_checked++;
        if (m_tdata !== e.addr) begin
          errors++;
          $display("%0t: alloc_addr expected %h actual %h", $time, e.addr, m_tdata);
        end
        if (m_tuser[0] !== e.found) begin
          errors++;
          $display("%0t: found expected %b actual %b", $time, e.found, m_tuser[0]);
        end
        if (m_tuser[1] !== e.dropped) begin
          errors++;
          $display("%0t: dropped expected %b actual %b", $time, e.dropped, m_tuser[1]);
        end
      end
    end
    if (calm) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      idle = idle_len();
      m_tready <= (idle == 0);
      if (idle > 0) stall_left = idle - 1;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout, %0d results still pending", $time, reply_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random_mix(950);
    test_drain_pause();
    test_back_to_back();
    s_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Ran %0d requests: %0d grants, %0d misses, %0d drops, %0d results checked.",
             n_sent, n_granted, n_missed, n_dropped, n_checked);
    $display("Covered zero sizes, exact fits, ties, address wrap and a full table under stalls.");
    if (errors == 0 && reply_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bfbp_pkg.sv
src/bfbp_front.sv
src/bfbp_back.sv
src/best_fit_block_pool.sv
tb/tb_best_fit_block_pool.sv
